// ===== src/ppm_frame_generator_core_defines.svh =====
// Assertion macros used by the PPM frame generator sequencer.
// Each macro expects clk and rst_n in scope at the point of use.
`ifndef PPM_FRAME_GENERATOR_CORE_DEFINES_SVH
`define PPM_FRAME_GENERATOR_CORE_DEFINES_SVH

// Same-cycle implication, ignored while in reset.
`define PPMFG_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, ignored while in reset.
`define PPMFG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/ppmfg_pkg.sv =====
// Shared types and constants for the PPM frame generator.
// No dependencies; used by every module of the block.
package ppmfg_pkg;

  localparam int MAX_CHANNELS = 8;
  localparam int TICK_BITS    = 16;

  localparam int CH_IDX_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int N_W       = $clog2(MAX_CHANNELS + 1);
  localparam int SEG_W     = $clog2(2 * MAX_CHANNELS + 3);
  localparam int LEN_W     = 26;
  localparam int SUM_W     = 20;
  localparam int VAL_W     = 16;
  localparam int PW_W      = 12;
  localparam int CC_W      = 4;
  localparam int IDX_W     = 3;
  localparam int OUT_SEG_W = 5;
  localparam int PADDR_W   = 5;
  localparam int PDATA_W   = 32;

  localparam logic [TICK_BITS-1:0] TICK_MAX   = '1;
  localparam logic [SUM_W-1:0]     SUM_MAX    = '1;
  localparam logic [VAL_W-1:0]     CH_RST_VAL = VAL_W'(1000);

  typedef enum logic [2:0] {
    REG_ENABLE        = 3'd0,
    REG_PULSE_WIDTH   = 3'd1,
    REG_FRAME_PERIOD  = 3'd2,
    REG_CHANNEL_COUNT = 3'd3,
    REG_MIN_VALUE     = 3'd4,
    REG_MAX_VALUE     = 3'd5,
    REG_ACTIVE_LEVEL  = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic             enable;
    logic [PW_W-1:0]  pulse_width;
    logic [VAL_W-1:0] frame_period;
    logic [CC_W-1:0]  channel_count;
    logic [VAL_W-1:0] min_value;
    logic [VAL_W-1:0] max_value;
    logic             active_level;
  } cfg_t;

  typedef struct packed {
    logic                 ppm_out;
    logic                 frame_start;
    logic [OUT_SEG_W-1:0] segment_index;
    logic                 sync_active;
    logic                 gap_clamped;
  } res_t;

endpackage

// ===== src/ppmfg_cfg.sv =====
// APB-style configuration registers of the PPM frame generator.
// Depends on ppmfg_pkg; issues a restart pulse when enable is written to 0.
module ppmfg_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ppmfg_pkg::PADDR_W-1:0] paddr,
  input  logic [ppmfg_pkg::PDATA_W-1:0] pwdata,
  output logic [ppmfg_pkg::PDATA_W-1:0] prdata,
  output logic                          pready,
  output ppmfg_pkg::cfg_t               cfg,
  output logic                          restart
);

  ppmfg_pkg::cfg_t cfg_r, cfg_nxt;
  ppmfg_pkg::reg_idx_t reg_idx;
  logic wr_en;

  assign reg_idx = ppmfg_pkg::reg_idx_t'(paddr[4:2]);
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;
  assign cfg     = cfg_r;
  assign restart = wr_en && (reg_idx == ppmfg_pkg::REG_ENABLE) && !pwdata[0];

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_idx)
        ppmfg_pkg::REG_ENABLE:        cfg_nxt.enable        = pwdata[0];
        ppmfg_pkg::REG_PULSE_WIDTH:   cfg_nxt.pulse_width   = pwdata[ppmfg_pkg::PW_W-1:0];
        ppmfg_pkg::REG_FRAME_PERIOD:  cfg_nxt.frame_period  = pwdata[ppmfg_pkg::VAL_W-1:0];
        ppmfg_pkg::REG_CHANNEL_COUNT: cfg_nxt.channel_count = pwdata[ppmfg_pkg::CC_W-1:0];
        ppmfg_pkg::REG_MIN_VALUE:     cfg_nxt.min_value     = pwdata[ppmfg_pkg::VAL_W-1:0];
        ppmfg_pkg::REG_MAX_VALUE:     cfg_nxt.max_value     = pwdata[ppmfg_pkg::VAL_W-1:0];
        ppmfg_pkg::REG_ACTIVE_LEVEL:  cfg_nxt.active_level  = pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      ppmfg_pkg::REG_ENABLE:        prdata = ppmfg_pkg::PDATA_W'(cfg_r.enable);
      ppmfg_pkg::REG_PULSE_WIDTH:   prdata = ppmfg_pkg::PDATA_W'(cfg_r.pulse_width);
      ppmfg_pkg::REG_FRAME_PERIOD:  prdata = ppmfg_pkg::PDATA_W'(cfg_r.frame_period);
      ppmfg_pkg::REG_CHANNEL_COUNT: prdata = ppmfg_pkg::PDATA_W'(cfg_r.channel_count);
      ppmfg_pkg::REG_MIN_VALUE:     prdata = ppmfg_pkg::PDATA_W'(cfg_r.min_value);
      ppmfg_pkg::REG_MAX_VALUE:     prdata = ppmfg_pkg::PDATA_W'(cfg_r.max_value);
      ppmfg_pkg::REG_ACTIVE_LEVEL:  prdata = ppmfg_pkg::PDATA_W'(cfg_r.active_level);
      default:                      prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable        <= 1'b0;
      cfg_r.pulse_width   <= ppmfg_pkg::PW_W'(300);
      cfg_r.frame_period  <= ppmfg_pkg::VAL_W'(20000);
      cfg_r.channel_count <= ppmfg_pkg::CC_W'(6);
      cfg_r.min_value     <= ppmfg_pkg::VAL_W'(1000);
      cfg_r.max_value     <= ppmfg_pkg::VAL_W'(2000);
      cfg_r.active_level  <= 1'b1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ===== src/ppmfg_chan_mem.sv =====
// Channel value memory: clamps writes, prefetches one entry with a registered read.
// Depends on ppmfg_pkg; unwritten entries read as the reset channel value.
module ppmfg_chan_mem (
  input  logic                           clk,
  input  logic                           rst_n,
  input  ppmfg_pkg::cfg_t                cfg,
  input  logic                           wr_req,
  input  logic [ppmfg_pkg::IDX_W-1:0]    wr_index,
  input  logic [ppmfg_pkg::VAL_W-1:0]    wr_value,
  input  logic [ppmfg_pkg::CH_IDX_W-1:0] rd_addr,
  output logic [ppmfg_pkg::VAL_W-1:0]    rd_data
);

  logic [ppmfg_pkg::VAL_W-1:0] mem [ppmfg_pkg::MAX_CHANNELS];
  logic [ppmfg_pkg::MAX_CHANNELS-1:0] vld_r;
  logic [ppmfg_pkg::VAL_W-1:0] rd_mem_r, fwd_data_r, lim_val, clamp_val;
  logic fwd_r, rd_vld_r, wr_en;
  logic [ppmfg_pkg::CH_IDX_W-1:0] wr_addr;

  // limit to max first, then raise to min so min wins
  assign lim_val   = (wr_value > cfg.max_value) ? cfg.max_value : wr_value;
  assign clamp_val = (lim_val < cfg.min_value) ? cfg.min_value : lim_val;
  assign wr_en     = wr_req && (32'(wr_index) < ppmfg_pkg::MAX_CHANNELS);
  assign wr_addr   = ppmfg_pkg::CH_IDX_W'(wr_index);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= clamp_val;
    end
    rd_mem_r   <= mem[rd_addr];
    fwd_data_r <= clamp_val;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      fwd_r    <= 1'b0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      fwd_r    <= wr_en && (wr_addr == rd_addr);
      rd_vld_r <= vld_r[rd_addr];
    end
  end

  always_comb begin
    if (fwd_r) begin
      rd_data = fwd_data_r;
    end else if (rd_vld_r) begin
      rd_data = rd_mem_r;
    end else begin
      rd_data = ppmfg_pkg::CH_RST_VAL;
    end
  end

endmodule

// ===== src/ppmfg_seq.sv =====
// Frame sequencer: segment counter, tick counter and frame sum, result per item.
// Depends on ppmfg_pkg and the assertion macros; reads channels via prefetch.
`include "ppm_frame_generator_core_defines.svh"

module ppmfg_seq (
  input  logic                           clk,
  input  logic                           rst_n,
  input  ppmfg_pkg::cfg_t                cfg,
  input  logic                           restart,
  input  logic                           tick,
  input  logic [ppmfg_pkg::VAL_W-1:0]    rd_data,
  output logic [ppmfg_pkg::CH_IDX_W-1:0] rd_addr,
  output ppmfg_pkg::res_t                res
);

  typedef struct packed {
    logic [ppmfg_pkg::TICK_BITS-1:0] len;
    logic                            clamped;
  } fit_t;

  function automatic fit_t fit_len(input logic signed [ppmfg_pkg::LEN_W-1:0] len);
    fit_t f;
    f.clamped = 1'b0;
    if (len < $signed(ppmfg_pkg::LEN_W'(1))) begin
      f.len     = ppmfg_pkg::TICK_BITS'(1);
      f.clamped = 1'b1;
    end else if (len > $signed(ppmfg_pkg::LEN_W'(ppmfg_pkg::TICK_MAX))) begin
      f.len = ppmfg_pkg::TICK_MAX;
    end else begin
      f.len = ppmfg_pkg::TICK_BITS'(len);
    end
    return f;
  endfunction

  logic [ppmfg_pkg::SEG_W-1:0]     seg_r, seg_nxt, seg_inc, start_seg, last_seg;
  logic [ppmfg_pkg::TICK_BITS-1:0] ticks_r, ticks_nxt;
  logic [ppmfg_pkg::SUM_W-1:0]     sum_r, sum_nxt, sum_base, sum_sat;
  logic [ppmfg_pkg::SUM_W:0]       sum_add;
  logic                            sync_r, sync_nxt;
  logic [ppmfg_pkg::N_W-1:0]       n_ch;
  logic [ppmfg_pkg::PW_W-1:0]      pw_eff;
  logic [ppmfg_pkg::SEG_W-2:0]     rd_half;
  logic signed [ppmfg_pkg::LEN_W-1:0] mark_len, gap_len, sync_len;
  fit_t                            fit;
  logic                            is_gap, is_sync, fstart, clamped, running;

  always_comb begin
    if (cfg.channel_count == '0) begin
      n_ch = ppmfg_pkg::N_W'(1);
    end else if (32'(cfg.channel_count) > ppmfg_pkg::MAX_CHANNELS) begin
      n_ch = ppmfg_pkg::N_W'(ppmfg_pkg::MAX_CHANNELS);
    end else begin
      n_ch = ppmfg_pkg::N_W'(cfg.channel_count);
    end
  end

  assign pw_eff   = (cfg.pulse_width == '0) ? ppmfg_pkg::PW_W'(1) : cfg.pulse_width;
  assign last_seg = ppmfg_pkg::SEG_W'({n_ch, 1'b1});
  assign seg_inc  = seg_r + ppmfg_pkg::SEG_W'(1);

  // idle starts a frame; wrap past the sync gap, also when the count shrank
  assign start_seg = (ticks_r == '0 || seg_inc > last_seg) ? '0 : seg_inc;
  assign is_gap    = start_seg[0] && (start_seg < last_seg);
  assign is_sync   = start_seg[0] && !is_gap;

  assign sum_base = (start_seg == '0) ? '0 : sum_r;
  assign sum_add  = {1'b0, sum_base} + (ppmfg_pkg::SUM_W + 1)'(rd_data);
  assign sum_sat  = sum_add[ppmfg_pkg::SUM_W] ? ppmfg_pkg::SUM_MAX
                                               : sum_add[ppmfg_pkg::SUM_W-1:0];

  assign mark_len = $signed(ppmfg_pkg::LEN_W'(pw_eff));
  assign gap_len  = $signed(ppmfg_pkg::LEN_W'(rd_data)) - mark_len;
  assign sync_len = $signed(ppmfg_pkg::LEN_W'(cfg.frame_period)) - mark_len
                    - $signed(ppmfg_pkg::LEN_W'(sum_r));

  always_comb begin
    if (is_gap) begin
      fit = fit_len(gap_len);
    end else if (is_sync) begin
      fit = fit_len(sync_len);
    end else begin
      fit = fit_len(mark_len);
    end
  end

  always_comb begin
    seg_nxt   = seg_r;
    ticks_nxt = ticks_r;
    sum_nxt   = sum_r;
    sync_nxt  = sync_r;
    fstart    = 1'b0;
    clamped   = 1'b0;
    if (restart || (tick && !cfg.enable)) begin
      seg_nxt   = '0;
      ticks_nxt = '0;
      sum_nxt   = '0;
      sync_nxt  = 1'b0;
    end else if (tick) begin
      if (ticks_r == '0 || ticks_r == ppmfg_pkg::TICK_BITS'(1)) begin
        seg_nxt   = start_seg;
        ticks_nxt = fit.len;
        sync_nxt  = is_sync;
        clamped   = fit.clamped;
        fstart    = (start_seg == '0);
        if (is_gap) begin
          sum_nxt = sum_sat;
        end else if (start_seg == '0) begin
          sum_nxt = '0;
        end
      end else begin
        ticks_nxt = ticks_r - ppmfg_pkg::TICK_BITS'(1);
      end
    end
  end

  // prefetch the channel of the gap that follows the coming segment
  assign rd_half = seg_nxt[ppmfg_pkg::SEG_W-1:1];
  assign rd_addr = (32'(rd_half) < ppmfg_pkg::MAX_CHANNELS)
                   ? ppmfg_pkg::CH_IDX_W'(rd_half) : '0;

  assign running           = (ticks_nxt != '0);
  assign res.ppm_out       = (running && !seg_nxt[0]) ? cfg.active_level : !cfg.active_level;
  assign res.frame_start   = fstart;
  assign res.segment_index = running ? ppmfg_pkg::OUT_SEG_W'(seg_nxt) : '0;
  assign res.sync_active   = running && sync_nxt;
  assign res.gap_clamped   = clamped;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_r   <= '0;
      ticks_r <= '0;
      sum_r   <= '0;
      sync_r  <= 1'b0;
    end else begin
      seg_r   <= seg_nxt;
      ticks_r <= ticks_nxt;
      sum_r   <= sum_nxt;
      sync_r  <= sync_nxt;
    end
  end

  `PPMFG_ASSERT_NOW(a_idle_seg_zero, ticks_r == '0, seg_r == '0 && sum_r == '0,
    "idle with nonzero segment or frame sum")
  `PPMFG_ASSERT_NOW(a_seg_range, 1'b1,
    32'(seg_r) <= 2 * ppmfg_pkg::MAX_CHANNELS + 1, "segment counter out of range")
  `PPMFG_ASSERT_NOW(a_sync_odd, sync_r, seg_r[0], "sync flag on a marker segment")
  `PPMFG_ASSERT_NEXT(a_disable_idles, tick && !cfg.enable, ticks_r == '0,
    "disabled tick did not idle the generator")

endmodule

// ===== src/ppm_frame_generator_core.sv =====
// PPM frame generator: one item accepted per clock unless a held result stalls, its result
// registered in the next cycle. A channel write uses the memory write port while the
// sequencer prefetches the next gap's channel through the registered read port.
// Reset (synchronous, rst_n low) clears control state and configuration to defaults;
// channel entries read as 1000 until written, so no clearing pass is needed.
module ppm_frame_generator_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_command,
  input  logic [ppmfg_pkg::IDX_W-1:0]   in_channel_index,
  input  logic [ppmfg_pkg::VAL_W-1:0]   in_channel_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_ppm_out,
  output logic                          out_frame_start,
  output logic [ppmfg_pkg::OUT_SEG_W-1:0] out_segment_index,
  output logic                          out_sync_active,
  output logic                          out_gap_clamped,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ppmfg_pkg::PADDR_W-1:0] paddr,
  input  logic [ppmfg_pkg::PDATA_W-1:0] pwdata,
  output logic [ppmfg_pkg::PDATA_W-1:0] prdata,
  output logic                          pready
);

  ppmfg_pkg::cfg_t cfg;
  ppmfg_pkg::res_t res, res_r;
  logic restart, accept, tick, wr_req, out_valid_r;
  logic [ppmfg_pkg::CH_IDX_W-1:0] rd_addr;
  logic [ppmfg_pkg::VAL_W-1:0] rd_data;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign tick     = accept && !in_command;
  assign wr_req   = accept && in_command;

  ppmfg_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg),
    .restart (restart)
  );

  ppmfg_chan_mem u_mem (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .wr_req   (wr_req),
    .wr_index (in_channel_index),
    .wr_value (in_channel_value),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data)
  );

  ppmfg_seq u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .restart (restart),
    .tick    (tick),
    .rd_data (rd_data),
    .rd_addr (rd_addr),
    .res     (res)
  );

  // hold the result until taken; a new item may replace it in the same cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= accept || (out_valid_r && !out_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_ppm_out       = res_r.ppm_out;
  assign out_frame_start   = res_r.frame_start;
  assign out_segment_index = res_r.segment_index;
  assign out_sync_active   = res_r.sync_active;
  assign out_gap_clamped   = res_r.gap_clamped;

endmodule

// ===== verif/ppm_frame_generator_checker.sv =====
// Command codes shared by the testbench, and the result checker for the PPM frame generator.
// The checker watches the item, result and register channels and predicts every result.
// Depends on ppmfg_pkg for register codes, field widths and the result layout.
package ppmfg_tb_pkg;

  typedef enum logic {
    CMD_TICK  = 1'b0,
    CMD_WRITE = 1'b1
  } ppm_cmd_t;

endpackage

module ppm_frame_generator_checker
  import ppmfg_pkg::*;
  import ppmfg_tb_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic                 in_command,
  input  logic [IDX_W-1:0]     in_channel_index,
  input  logic [VAL_W-1:0]     in_channel_value,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic                 out_ppm_out,
  input  logic                 out_frame_start,
  input  logic [OUT_SEG_W-1:0] out_segment_index,
  input  logic                 out_sync_active,
  input  logic                 out_gap_clamped,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic                 pready,
  input  logic [PADDR_W-1:0]   paddr,
  input  logic [PDATA_W-1:0]   pwdata,
  output int                   mismatches,
  output int                   results_due
);

  cfg_t                 settings;
  logic [VAL_W-1:0]     slot_len [MAX_CHANNELS];
  int unsigned          seg_num;
  logic [TICK_BITS-1:0] ticks_left;
  logic [SUM_W-1:0]     frame_sum;
  logic                 pin_level;
  logic                 in_sync;
  res_t                 ppm_results_due [$];

  initial begin
    mismatches  = 0;
    results_due = 0;
  end

  function automatic int unsigned live_channels();
    if (settings.channel_count == '0) return 1;
    if (settings.channel_count > CC_W'(MAX_CHANNELS)) return MAX_CHANNELS;
    return int'(settings.channel_count);
  endfunction

  function automatic void set_pin();
    if (ticks_left != '0 && seg_num % 2 == 0) pin_level = settings.active_level;
    else pin_level = ~settings.active_level;
  endfunction

  function automatic void restart_frame();
    seg_num    = 0;
    ticks_left = '0;
    frame_sum  = '0;
    in_sync    = 1'b0;
    set_pin();
  endfunction

  function automatic void power_on();
    settings.enable        = 1'b0;
    settings.pulse_width   = PW_W'(300);
    settings.frame_period  = VAL_W'(20000);
    settings.channel_count = CC_W'(6);
    settings.min_value     = VAL_W'(1000);
    settings.max_value     = VAL_W'(2000);
    settings.active_level  = 1'b1;
    foreach (slot_len[i]) slot_len[i] = CH_RST_VAL;
    restart_frame();
  endfunction

  // Load segment s and return whether its gap had to be floored to one tick.
  function automatic bit start_segment(input int unsigned s);
    int unsigned n;
    longint      pw;
    longint      len;
    longint      total;
    longint      slot;
    bit          floored;
    n       = live_channels();
    pw      = longint'(settings.pulse_width);
    if (pw == 0) pw = 1;
    floored = 1'b0;
    seg_num = s;
    in_sync = 1'b0;
    if (s == 0) frame_sum = '0;
    if (s % 2 == 0) begin
      len = pw;
    end else if (s < 2 * n + 1) begin
      slot  = longint'(slot_len[((s - 1) / 2) % MAX_CHANNELS]);
      total = longint'(frame_sum) + slot;
      if (total > longint'(SUM_MAX)) total = longint'(SUM_MAX);
      frame_sum = SUM_W'(total);
      len = slot - pw;
    end else begin
      in_sync = 1'b1;
      len = longint'(settings.frame_period) - pw - longint'(frame_sum);
    end
    if (len < 1) begin
      floored = 1'b1;
      len = 1;
    end else if (len > longint'(TICK_MAX)) begin
      len = longint'(TICK_MAX);
    end
    ticks_left = TICK_BITS'(len);
    set_pin();
    return floored;
  endfunction

  function automatic res_t frame_step(input ppm_cmd_t cmd, input logic [IDX_W-1:0] idx,
                                      input logic [VAL_W-1:0] val);
    res_t        r;
    logic [VAL_W-1:0] v;
    int unsigned nxt;
    bit          fstart;
    bit          floored;
    fstart  = 1'b0;
    floored = 1'b0;
    v       = val;
    if (cmd == CMD_WRITE) begin
      // max first, then min, so min wins when the limits cross
      if (v > settings.max_value) v = settings.max_value;
      if (v < settings.min_value) v = settings.min_value;
      slot_len[idx] = v;
    end else if (!settings.enable) begin
      restart_frame();
    end else if (ticks_left == '0) begin
      floored = start_segment(0);
      fstart  = 1'b1;
    end else if (ticks_left == TICK_BITS'(1)) begin
      nxt = seg_num + 1;
      if (nxt > 2 * live_channels() + 1) nxt = 0;
      floored = start_segment(nxt);
      fstart  = (nxt == 0);
    end else begin
      ticks_left = ticks_left - TICK_BITS'(1);
    end
    r.ppm_out       = pin_level;
    r.frame_start   = fstart;
    r.segment_index = (ticks_left != '0) ? OUT_SEG_W'(seg_num) : '0;
    r.sync_active   = (ticks_left != '0) && in_sync;
    r.gap_clamped   = floored;
    return r;
  endfunction

  function automatic void take_setting(input logic [PADDR_W-1:0] addr,
                                       input logic [PDATA_W-1:0] d);
    case (reg_idx_t'(addr[PADDR_W-1:2]))
      REG_ENABLE: begin
        settings.enable = d[0];
        if (!d[0]) restart_frame();
      end
      REG_PULSE_WIDTH:   settings.pulse_width   = d[PW_W-1:0];
      REG_FRAME_PERIOD:  settings.frame_period  = d[VAL_W-1:0];
      REG_CHANNEL_COUNT: settings.channel_count = d[CC_W-1:0];
      REG_MIN_VALUE:     settings.min_value     = d[VAL_W-1:0];
      REG_MAX_VALUE:     settings.max_value     = d[VAL_W-1:0];
      REG_ACTIVE_LEVEL: begin
        settings.active_level = d[0];
        set_pin();
      end
      default: ;
    endcase
  endfunction

  function automatic void compare_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    res_t want;
    if (!rst_n) begin
      power_on();
      ppm_results_due.delete();
    end else begin
      if (psel && penable && pwrite && pready) take_setting(paddr, pwdata);
      if (in_valid && in_ready)
        ppm_results_due.push_back(frame_step(ppm_cmd_t'(in_command), in_channel_index,
                                             in_channel_value));
      if (out_valid && out_ready) begin
        if (ppm_results_due.size() == 0) begin
          $error("result item with no item pending");
          mismatches++;
        end else begin
          want = ppm_results_due.pop_front();
          compare_field("ppm_out", 32'(want.ppm_out), 32'(out_ppm_out));
          compare_field("frame_start", 32'(want.frame_start), 32'(out_frame_start));
          compare_field("segment_index", 32'(want.segment_index), 32'(out_segment_index));
          compare_field("sync_active", 32'(want.sync_active), 32'(out_sync_active));
          compare_field("gap_clamped", 32'(want.gap_clamped), 32'(out_gap_clamped));
        end
      end
    end
    results_due <= ppm_results_due.size();
  end

endmodule

// ===== verif/ppm_frame_generator_core_tb.sv =====
// Stimulus and verdict for ppm_frame_generator_core: register setups, directed and random
// items, random idling on both channels and two long result hold-offs.
// Depends on ppmfg_pkg, ppmfg_tb_pkg and ppm_frame_generator_checker.
module ppm_frame_generator_core_tb;
  import ppmfg_pkg::*;
  import ppmfg_tb_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 80;

  logic                 clk               = 1'b0;
  logic                 rst_n             = 1'b0;
  logic                 in_valid          = 1'b0;
  logic                 in_ready;
  logic                 in_command        = 1'b0;
  logic [IDX_W-1:0]     in_channel_index  = '0;
  logic [VAL_W-1:0]     in_channel_value  = '0;
  logic                 out_valid;
  logic                 out_ready         = 1'b0;
  logic                 out_ppm_out;
  logic                 out_frame_start;
  logic [OUT_SEG_W-1:0] out_segment_index;
  logic                 out_sync_active;
  logic                 out_gap_clamped;
  logic                 psel              = 1'b0;
  logic                 penable           = 1'b0;
  logic                 pwrite            = 1'b0;
  logic [PADDR_W-1:0]   paddr             = '0;
  logic [PDATA_W-1:0]   pwdata            = '0;
  logic [PDATA_W-1:0]   prdata;
  logic                 pready;

  int mismatches;
  int results_due;
  bit idling       = 1'b1;
  int holds_wanted = 0;
  int cycles       = 0;

  ppm_frame_generator_core dut (.*);

  ppm_frame_generator_checker checker_i (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Result side: random stalls, plus a long hold-off whenever one is requested.
  initial begin : result_sink
    int stall;
    int served;
    served = 0;
    forever begin
      @(posedge clk);
      if (served != holds_wanted) begin
        served = holds_wanted;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
      end else if (idling && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        stall = $urandom_range(1, 5);
        repeat (stall - 1) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic send_item(input ppm_cmd_t cmd, input logic [IDX_W-1:0] idx,
                           input logic [VAL_W-1:0] val);
    int gap;
    if (idling && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 5);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_command       <= cmd;
    in_channel_index <= idx;
    in_channel_value <= val;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_random(input int count, input int write_pct, input int value_hi);
    for (int k = 0; k < count; k++) begin
      ppm_cmd_t         cmd;
      logic [VAL_W-1:0] v;
      cmd = ($urandom_range(0, 99) < write_pct) ? CMD_WRITE : CMD_TICK;
      // mostly values near the clamp window, now and then any 16-bit value
      v = ($urandom_range(0, 9) == 0) ? VAL_W'($urandom) : VAL_W'($urandom_range(0, value_hi));
      send_item(cmd, IDX_W'($urandom_range(0, MAX_CHANNELS - 1)), v);
    end
  endtask

  // Drop valid and wait until every result item has come back.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (results_due != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t r, input int unsigned d);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= PDATA_W'(d);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_settings(input int unsigned en, input int unsigned pw,
                               input int unsigned period, input int unsigned count,
                               input int unsigned minv, input int unsigned maxv,
                               input int unsigned act);
    write_reg(REG_PULSE_WIDTH, pw);
    write_reg(REG_FRAME_PERIOD, period);
    write_reg(REG_CHANNEL_COUNT, count);
    write_reg(REG_MIN_VALUE, minv);
    write_reg(REG_MAX_VALUE, maxv);
    write_reg(REG_ACTIVE_LEVEL, act);
    write_reg(REG_ENABLE, en);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ticks while disabled keep the output idle
    send_item(CMD_TICK, '0, '0);
    send_item(CMD_TICK, '1, '1);
    drain();

    load_settings(1, 3, 60, 3, 5, 12, 1);
    send_item(CMD_WRITE, 3'd0, 16'd0);
    send_item(CMD_WRITE, 3'd1, 16'hFFFF);
    send_item(CMD_WRITE, 3'd2, 16'd7);
    send_item(CMD_WRITE, 3'd7, 16'h5555);
    send_item(CMD_WRITE, 3'd3, 16'hAAAA);
    for (int k = 0; k < 16; k++)
      send_item(CMD_TICK, IDX_W'(k), VAL_W'(k * 16'h1111));
    send_random(100, 20, 16);
    holds_wanted <= holds_wanted + 1;
    send_random(300, 20, 16);
    drain();

    // zero pulse width, active-low markers, floored channel and sync gaps
    load_settings(1, 0, 5, 2, 0, 3, 0);
    send_random(250, 20, 4);
    drain();

    // channel count of zero, one-tick frame period
    load_settings(1, 2, 1, 0, 4, 8, 1);
    send_random(150, 20, 10);
    drain();

    // channel count above the channel limit
    load_settings(1, 1, 200, 15, 2, 20, 1);
    send_random(300, 20, 24);
    drain();

    // shrink the frame mid-way, with crossed clamp limits
    write_reg(REG_CHANNEL_COUNT, 1);
    write_reg(REG_MIN_VALUE, 10);
    write_reg(REG_MAX_VALUE, 3);
    send_random(150, 20, 16);
    drain();

    // disable restarts the frame, then resume with the other active level
    write_reg(REG_ENABLE, 0);
    send_random(40, 20, 16);
    drain();
    write_reg(REG_ENABLE, 1);
    write_reg(REG_ACTIVE_LEVEL, 0);
    send_random(40, 20, 16);
    drain();

    // widest pulse, longest period and open clamp window
    load_settings(1, 4095, 65535, 8, 0, 65535, 1);
    send_random(60, 20, 65535);
    drain();
    write_reg(REG_MIN_VALUE, 65535);
    write_reg(REG_MAX_VALUE, 0);
    send_random(20, 50, 65535);
    drain();

    load_settings(1, 5, 100, 4, 6, 30, 1);
    send_random(150, 15, 40);
    holds_wanted <= holds_wanted + 1;
    send_random(150, 15, 40);
    idling <= 1'b0;
    send_random(200, 15, 40);
    drain();

    if (mismatches == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
